/* hdl/encoder_speed_and_bridge_drive_top_defines.svh */
// assertion macros for the encoder speed and bridge drive block
`ifndef ENCODER_SPEED_AND_BRIDGE_DRIVE_TOP_DEFINES_SVH
`define ENCODER_SPEED_AND_BRIDGE_DRIVE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ESBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ESBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ESBD_ASSERT_NOW(lbl, ante, cons, msg)
`define ESBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/esbd_pkg.sv */
package esbd_pkg;

    localparam int KIND_W      = 2;
    localparam int DRIVE_W     = 17;
    localparam int COUNT_W     = 16;
    localparam int WORD_W      = 32;
    localparam int CMP_W       = 16;
    localparam int US_PER_S_W  = 20;
    // |count| * 1e6 stays below 2^35
    localparam int DIVIDEND_W  = 35;
    localparam int DIVISOR_W   = WORD_W;
    localparam int PWM_MAX_DEF = 65535;

    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hdl/esbd_stream_if.sv */
interface esbd_in_if
    import esbd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic                      enc_a;
    logic                      enc_b;
    logic signed [DRIVE_W-1:0] drive_value;
    logic [WORD_W-1:0]         time_us;

    modport source (output valid, kind, enc_a, enc_b, drive_value, time_us, input ready);
    modport sink   (input valid, kind, enc_a, enc_b, drive_value, time_us, output ready);
endinterface

interface esbd_out_if
    import esbd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     bridge_in1;
    logic                     bridge_in2;
    logic [CMP_W-1:0]         compare_value;
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] speed;

    modport source (output valid, bridge_in1, bridge_in2, compare_value, position, speed,
                    input ready);
    modport sink   (input valid, bridge_in1, bridge_in2, compare_value, position, speed,
                    output ready);
endinterface

/* hdl/encoder_speed_and_bridge_drive_top.sv */
// edge and set-drive transfers: one per cycle while input ready is high, no result
// update tick: result passes the multiply state, 35 divider steps, the done state and the
//   output load; the divider is skipped when no time has elapsed
// input ready is low from a tick transfer until its result is loaded; a held result
//   blocks only the next load
// async active-low reset clears count, position, last timestamp and drive to 0
module encoder_speed_and_bridge_drive_top
    import esbd_pkg::*;
#(
    parameter int PWM_MAX = PWM_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    esbd_in_if.sink    in_ch,
    esbd_out_if.source out_ch
);

`include "encoder_speed_and_bridge_drive_top_defines.svh"

    localparam logic [DRIVE_W-1:0] PWM_LIMIT = DRIVE_W'(PWM_MAX);
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] POS_LIMIT = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] NEG_LIMIT = {1'b1, {(WORD_W-1){1'b0}}};

    // sequencer
    state_t state_reg;
    state_t state_next;

    // architectural state
    logic signed [COUNT_W-1:0] edge_count_reg;
    logic signed [COUNT_W-1:0] edge_count_next;
    logic [WORD_W-1:0]         position_acc_reg;
    logic [WORD_W-1:0]         position_acc_next;
    logic [WORD_W-1:0]         last_tick_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // tick in flight
    logic                  neg_reg;
    logic [COUNT_W-1:0]    mag_reg;
    logic [WORD_W-1:0]     elapsed_reg;
    logic                  zero_time_reg;
    logic                  pend_in1_reg;
    logic                  pend_in2_reg;
    logic [CMP_W-1:0]      pend_cmp_reg;
    logic [WORD_W-1:0]     pend_pos_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_in1_reg;
    logic                  out_in2_reg;
    logic [CMP_W-1:0]      out_cmp_reg;
    logic [WORD_W-1:0]     out_pos_reg;
    logic [WORD_W-1:0]     out_speed_reg;

    logic in_fire;
    logic is_tick;
    logic div_start;
    logic out_load;
    logic div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVIDEND_W-1:0] dividend;
    logic [WORD_W-1:0]     speed_sat;
    logic [WORD_W-1:0]     elapsed_now;
    logic [DRIVE_W-1:0]    drive_mag;
    logic [COUNT_W-1:0]    count_mag;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_tick     = (in_ch.kind == KIND_TICK);

    // x2 decode: up when levels match, down otherwise, held at the limits
    always_comb
    begin
        edge_count_next   = edge_count_reg;
        position_acc_next = position_acc_reg;
        if (in_fire)
        begin
            case (in_ch.kind)
                KIND_EDGE:
                begin
                    if (in_ch.enc_a == in_ch.enc_b)
                    begin
                        if (edge_count_reg != COUNT_MAX)
                            edge_count_next = edge_count_reg + COUNT_W'(1);
                    end
                    else if (edge_count_reg != COUNT_MIN)
                    begin
                        edge_count_next = edge_count_reg - COUNT_W'(1);
                    end
                end
                KIND_TICK:
                begin
                    edge_count_next   = '0;
                    position_acc_next = position_acc_reg
                                        + WORD_W'(signed'(edge_count_reg));
                end
                default:
                begin
                    edge_count_next = edge_count_reg;
                end
            endcase
        end
    end

    // elapsed time wraps modulo 2^32
    assign elapsed_now = in_ch.time_us - last_tick_reg;
    assign count_mag   = edge_count_reg[COUNT_W-1] ? (COUNT_W'(0) - edge_count_reg)
                                                   : edge_count_reg;
    // most negative drive gives 65536, which the compare limit catches
    assign drive_mag   = drive_reg[DRIVE_W-1] ? (DRIVE_W'(0) - drive_reg) : drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg   <= '0;
            position_acc_reg <= '0;
            last_tick_reg    <= '0;
            drive_reg        <= '0;
        end
        else
        begin
            edge_count_reg   <= edge_count_next;
            position_acc_reg <= position_acc_next;
            if (in_fire && is_tick)
                last_tick_reg <= in_ch.time_us;
            if (in_fire && (in_ch.kind == KIND_DRIVE))
                drive_reg <= in_ch.drive_value;
        end
    end

    // snapshot of everything the tick result needs
    always_ff @(posedge clk)
    begin
        if (in_fire && is_tick)
        begin
            neg_reg       <= edge_count_reg[COUNT_W-1];
            mag_reg       <= count_mag;
            elapsed_reg   <= elapsed_now;
            zero_time_reg <= (elapsed_now == '0);
            pend_in1_reg  <= !drive_reg[DRIVE_W-1];
            pend_in2_reg  <= drive_reg[DRIVE_W-1] || (drive_reg == '0);
            pend_cmp_reg  <= (drive_mag > PWM_LIMIT) ? PWM_LIMIT[CMP_W-1:0]
                                                     : drive_mag[CMP_W-1:0];
            pend_pos_reg  <= position_acc_next;
        end
    end

    // counts times one million, registered inside the divider
    assign dividend = DIVIDEND_W'(mag_reg) * DIVIDEND_W'(US_PER_S);

    esbd_divider #(
        .NUM_W (DIVIDEND_W),
        .DEN_W (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // truncated quotient saturated into signed 32 bits, or 0 when no time has elapsed
    always_comb
    begin
        if (zero_time_reg)
            speed_sat = '0;
        else if (neg_reg)
            speed_sat = (quotient > DIVIDEND_W'(NEG_LIMIT)) ? NEG_LIMIT
                                                            : (WORD_W'(0) - quotient[WORD_W-1:0]);
        else
            speed_sat = (quotient > DIVIDEND_W'(POS_LIMIT)) ? POS_LIMIT
                                                            : quotient[WORD_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_tick)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = zero_time_reg ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_MUL:  div_start = !zero_time_reg;
            ST_DONE: out_load  = !out_valid_reg || out_ch.ready;
            default:
            begin
                div_start = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_in1_reg   <= pend_in1_reg;
            out_in2_reg   <= pend_in2_reg;
            out_cmp_reg   <= pend_cmp_reg;
            out_pos_reg   <= pend_pos_reg;
            out_speed_reg <= speed_sat;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bridge_in1    = out_in1_reg;
    assign out_ch.bridge_in2    = out_in2_reg;
    assign out_ch.compare_value = out_cmp_reg;
    assign out_ch.position      = out_pos_reg;
    assign out_ch.speed         = out_speed_reg;

    // divider only finishes while the sequencer waits on it
    `ESBD_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider done outside wait")
    // tick transfer clears the edge count
    `ESBD_ASSERT_NEXT(a_tick_clears, in_fire && is_tick, edge_count_reg == '0, "count not cleared")
    // the bridge never sees both inputs low
    `ESBD_ASSERT_NOW(a_bridge_safe, out_valid_reg, out_in1_reg || out_in2_reg, "bridge both low")

endmodule

/* hdl/esbd_divider.sv */
module esbd_divider
    import esbd_pkg::*;
#(
    parameter int NUM_W = DIVIDEND_W,
    parameter int DEN_W = DIVISOR_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // one quotient bit per cycle, restoring form
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
